>>> rtl/byte_ring_buffer_macros.svh
`ifndef BYTE_RING_BUFFER_MACROS_SVH
`define BYTE_RING_BUFFER_MACROS_SVH

// same-cycle implication, sampled on aclk, off during reset
`define BRB_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("byte ring buffer check failed");

// next-cycle implication, sampled on aclk, off during reset
`define BRB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("byte ring buffer check failed");

`endif

>>> rtl/brb_pkg.sv
`timescale 1ns / 1ps

package brb_pkg;

    localparam int BANKS  = 8;
    localparam int LANE_W = 3;

    localparam logic [2:0] OP_PUSH     = 3'd0;
    localparam logic [2:0] OP_POP      = 3'd1;
    localparam logic [2:0] OP_PICK     = 3'd2;
    localparam logic [2:0] OP_SKIP     = 3'd3;
    localparam logic [2:0] OP_CLEAR    = 3'd4;
    localparam logic [2:0] OP_TRY_POP  = 3'd5;
    localparam logic [2:0] OP_TRY_PICK = 3'd6;

    typedef struct packed {
        logic wr;
        logic rd;
    } brb_bank_ctl_t;

endpackage

>>> rtl/brb_bank.sv
`timescale 1ns / 1ps

module brb_bank
    import brb_pkg::*;
#(
    parameter int ROWS = 128
) (
    input  logic                      aclk,
    input  brb_bank_ctl_t             ctl,
    input  logic [$clog2(ROWS)-1:0]   wr_row,
    input  logic [7:0]                wr_data,
    input  logic [$clog2(ROWS)-1:0]   rd_row,
    output logic [7:0]                rd_data
);

    logic [7:0] mem [ROWS];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr) begin
            mem[wr_row] <= wr_data;
        end
        if (ctl.rd) begin
            rd_data_reg <= mem[rd_row];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/brb_merge.sv
`timescale 1ns / 1ps

module brb_merge
    import brb_pkg::*;
(
    input  logic [8*BANKS-1:0] bank_q,
    input  logic [LANE_W-1:0]  offset,
    input  logic [3:0]         count,
    output logic [8*BANKS-1:0] data_out
);

    // rotate banks so the oldest byte lands in lane 0, zero lanes past count
    always_comb begin
        logic [LANE_W-1:0] sel;
        data_out = '0;
        sel      = '0;
        for (int i = 0; i < BANKS; i++) begin
            sel = LANE_W'(offset + LANE_W'(i));
            if (4'(i) < count) begin
                data_out[8*i +: 8] = bank_q[8*sel +: 8];
            end
        end
    end

endmodule

>>> rtl/byte_ring_buffer.sv
// An accepted word passes the bank read and result registers, then the
// output registers. No new request is taken while the last waits on the
// registered read of the eight byte banks, or while the output stalls.
// Reset (aresetn low, synchronous): pointers and fill level go to zero and
// the output empties; the byte store is not cleared.
`timescale 1ns / 1ps

module byte_ring_buffer
    import brb_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int LANES = 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [2:0]                   s_operation,
    input  logic [3:0]                   s_length,
    input  logic [63:0]                  s_data_in,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_ok,
    output logic [3:0]                   m_count,
    output logic [63:0]                  m_data_out,
    output logic [$clog2(DEPTH+1)-1:0]   m_fill_level
);

    localparam int PW   = $clog2(DEPTH);
    localparam int FW   = $clog2(DEPTH + 1);
    localparam int ROWS = DEPTH / BANKS;
    localparam int RW   = PW - LANE_W;

    logic [PW-1:0] rp_reg, rp_next;
    logic [PW-1:0] wp_reg, wp_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic          busy_reg;

    logic              res_ok_reg;
    logic [3:0]        res_cnt_reg;
    logic [3:0]        res_rd_cnt_reg;
    logic [LANE_W-1:0] res_off_reg;
    logic [FW-1:0]     res_fill_reg;

    logic          m_valid_reg;
    logic          m_ok_reg;
    logic [3:0]    m_count_reg;
    logic [63:0]   m_data_out_reg;
    logic [FW-1:0] m_fill_level_reg;

    logic          accept;
    logic          ok, do_write, do_read, do_drop, do_clear;
    logic [3:0]    cnt;
    logic          fits_lanes, push_fit, need_ok;
    logic [3:0]    try_cnt, lim_cnt;
    logic [FW-1:0] fill_left;

    logic [8*BANKS-1:0] bank_q;
    logic [63:0]        merged;

    function automatic logic [PW-1:0] add_wrap(input logic [PW-1:0] p, input logic [3:0] n);
        logic [PW:0] sum;
        sum = {1'b0, p} + (PW+1)'(n);
        if (sum >= (PW+1)'(DEPTH)) begin
            sum = sum - (PW+1)'(DEPTH);
        end
        return sum[PW-1:0];
    endfunction

    function automatic logic [RW-1:0] row_inc(input logic [RW-1:0] r);
        logic [RW-1:0] nr;
        nr = (r == RW'(ROWS - 1)) ? '0 : RW'(r + 1'b1);
        return nr;
    endfunction

    assign s_ready = !busy_reg && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    // request decode
    always_comb begin
        fits_lanes = (s_length <= 4'(LANES));
        push_fit   = (s_length != 4'd0) && fits_lanes &&
                     (({1'b0, fill_reg} + (FW+1)'(s_length)) <= (FW+1)'(DEPTH));
        need_ok    = (s_length == 4'd0) || (fits_lanes && (FW'(s_length) <= fill_reg));
        lim_cnt    = fits_lanes ? s_length : 4'(LANES);
        try_cnt    = (FW'(lim_cnt) > fill_reg) ? fill_reg[3:0] : lim_cnt;

        ok       = 1'b0;
        cnt      = 4'd0;
        do_write = 1'b0;
        do_read  = 1'b0;
        do_drop  = 1'b0;
        do_clear = 1'b0;
        case (s_operation)
            OP_PUSH: begin
                ok       = push_fit;
                cnt      = push_fit ? s_length : 4'd0;
                do_write = push_fit;
            end
            OP_POP, OP_PICK, OP_SKIP: begin
                ok      = need_ok;
                cnt     = need_ok ? s_length : 4'd0;
                do_read = need_ok && (s_operation != OP_SKIP);
                do_drop = need_ok && (s_operation != OP_PICK);
            end
            OP_CLEAR: begin
                ok       = 1'b1;
                do_clear = 1'b1;
            end
            OP_TRY_POP, OP_TRY_PICK: begin
                ok      = 1'b1;
                cnt     = try_cnt;
                do_read = 1'b1;
                do_drop = (s_operation == OP_TRY_POP);
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    // pointer and fill update
    always_comb begin
        rp_next   = rp_reg;
        wp_next   = wp_reg;
        fill_next = fill_reg;
        fill_left = fill_reg - FW'(cnt);
        if (do_clear) begin
            rp_next   = '0;
            wp_next   = '0;
            fill_next = '0;
        end else if (do_write) begin
            wp_next   = add_wrap(wp_reg, cnt);
            fill_next = fill_reg + FW'(cnt);
        end else if (do_drop) begin
            fill_next = fill_left;
            if (fill_left == '0) begin
                rp_next = '0;
                wp_next = '0;
            end else begin
                rp_next = add_wrap(rp_reg, cnt);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rp_reg   <= '0;
            wp_reg   <= '0;
            fill_reg <= '0;
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= accept;
            if (accept) begin
                rp_reg   <= rp_next;
                wp_reg   <= wp_next;
                fill_reg <= fill_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_ok_reg     <= ok;
            res_cnt_reg    <= cnt;
            res_rd_cnt_reg <= do_read ? cnt : 4'd0;
            res_off_reg    <= rp_reg[LANE_W-1:0];
            res_fill_reg   <= fill_next;
        end
    end

    genvar b;
    generate
        for (b = 0; b < BANKS; b++) begin : g_bank
            logic [LANE_W-1:0] wl;
            logic [RW-1:0]     wrow, rrow;
            brb_bank_ctl_t     ctl;

            assign wl   = LANE_W'(b) - wp_reg[LANE_W-1:0];
            assign wrow = (LANE_W'(b) < wp_reg[LANE_W-1:0]) ?
                          row_inc(wp_reg[PW-1:LANE_W]) : wp_reg[PW-1:LANE_W];
            assign rrow = (LANE_W'(b) < rp_reg[LANE_W-1:0]) ?
                          row_inc(rp_reg[PW-1:LANE_W]) : rp_reg[PW-1:LANE_W];
            assign ctl.wr = accept && do_write && (4'(wl) < cnt);
            assign ctl.rd = accept && do_read;

            brb_bank #(
                .ROWS (ROWS)
            ) u_bank (
                .aclk    (aclk),
                .ctl     (ctl),
                .wr_row  (wrow),
                .wr_data (s_data_in[8*wl +: 8]),
                .rd_row  (rrow),
                .rd_data (bank_q[8*b +: 8])
            );
        end
    endgenerate

    brb_merge u_merge (
        .bank_q   (bank_q),
        .offset   (res_off_reg),
        .count    (res_rd_cnt_reg),
        .data_out (merged)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (busy_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            m_ok_reg         <= res_ok_reg;
            m_count_reg      <= res_cnt_reg;
            m_data_out_reg   <= merged;
            m_fill_level_reg <= res_fill_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_ok         = m_ok_reg;
    assign m_count      = m_count_reg;
    assign m_data_out   = m_data_out_reg;
    assign m_fill_level = m_fill_level_reg;

endmodule

>>> rtl/brb_checker.sv
`timescale 1ns / 1ps
`include "byte_ring_buffer_macros.svh"

module brb_checker #(
    parameter int DEPTH = 1024,
    parameter int LANES = 8
) (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic                         m_ok,
    input logic [3:0]                   m_count,
    input logic [63:0]                  m_data_out,
    input logic [$clog2(DEPTH+1)-1:0]   m_fill_level
);

    localparam int FW = $clog2(DEPTH + 1);

    `BRB_ASSERT_NEXT(a_word_result, s_valid && s_ready, !s_ready ##1 m_valid)
    `BRB_ASSERT_IMPL(a_refused_empty, m_valid && !m_ok, m_count == 4'd0 && m_data_out == 64'd0)
    `BRB_ASSERT_IMPL(a_bounds, m_valid, m_count <= 4'(LANES) && m_fill_level <= FW'(DEPTH))
    `BRB_ASSERT_NEXT(a_hold_stall, m_valid && !m_ready, m_valid && $stable(m_data_out))

endmodule

bind byte_ring_buffer brb_checker #(
    .DEPTH (DEPTH),
    .LANES (LANES)
) u_brb_checker (.*);

>>> dv/tb_byte_ring_buffer.sv
`timescale 1ns / 1ps

module tb_byte_ring_buffer;
    import brb_pkg::*;

    localparam int DEPTH = 1024;
    localparam int LANES = 8;
    localparam int LVL_W = $clog2(DEPTH + 1);
    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam int PHASE_WORDS = 170;
    localparam int PHASES = 9;

    typedef enum int {MODE_FILL, MODE_MIXED, MODE_DRAIN} traffic_mode_t;

    typedef struct {
        logic             ok;
        logic [3:0]       count;
        logic [63:0]      data;
        logic [LVL_W-1:0] level;
    } reply_t;

    class ring_mirror;
        logic [7:0] bytes_held [DEPTH];
        int rd_ptr;
        int wr_ptr;
        int fill;
        int errors;
        reply_t pending_replies[$];

        function new();
            rd_ptr = 0;
            wr_ptr = 0;
            fill = 0;
            errors = 0;
            foreach (bytes_held[i]) bytes_held[i] = 8'd0;
        endfunction

        function logic [63:0] peek_bytes(int n);
            logic [63:0] v;
            v = 64'd0;
            for (int i = 0; i < n; i++) v[8*i +: 8] = bytes_held[(rd_ptr + i) % DEPTH];
            return v;
        endfunction

        function void drop_bytes(int n);
            rd_ptr = (rd_ptr + n) % DEPTH;
            fill -= n;
            if (fill == 0) begin
                rd_ptr = 0;
                wr_ptr = 0;
            end
        endfunction

        function void note_request(logic [2:0] op, logic [3:0] len, logic [63:0] din);
            reply_t r;
            int n;
            r.ok = 1'b0;
            r.count = 4'd0;
            r.data = 64'd0;
            case (op)
                OP_PUSH: begin
                    if (len != 0 && len <= LANES && fill + len <= DEPTH) begin
                        for (int i = 0; i < len; i++) begin
                            bytes_held[wr_ptr] = din[8*i +: 8];
                            wr_ptr = (wr_ptr + 1) % DEPTH;
                        end
                        fill += len;
                        r.ok = 1'b1;
                        r.count = len;
                    end
                end
                OP_POP, OP_PICK, OP_SKIP: begin
                    if (len == 0) begin
                        r.ok = 1'b1;
                    end else if (len <= LANES && len <= fill) begin
                        r.ok = 1'b1;
                        r.count = len;
                        if (op != OP_SKIP) r.data = peek_bytes(len);
                        if (op != OP_PICK) drop_bytes(len);
                    end
                end
                OP_CLEAR: begin
                    rd_ptr = 0;
                    wr_ptr = 0;
                    fill = 0;
                    r.ok = 1'b1;
                end
                OP_TRY_POP, OP_TRY_PICK: begin
                    n = len;
                    if (n > LANES) n = LANES;
                    if (n > fill) n = fill;
                    r.ok = 1'b1;
                    r.count = 4'(n);
                    if (n > 0) begin
                        r.data = peek_bytes(n);
                        if (op == OP_TRY_POP) drop_bytes(n);
                    end
                end
                default: begin
                end
            endcase
            r.level = LVL_W'(fill);
            pending_replies.push_back(r);
        endfunction

        function void check_reply(logic ok, logic [3:0] count, logic [63:0] data,
                                  logic [LVL_W-1:0] level);
            reply_t e;
            if (pending_replies.size() == 0) begin
                errors++;
                $display("%0t: unexpected word ok=%0d count=%0d data=%h level=%0d",
                         $time, ok, count, data, level);
                return;
            end
            e = pending_replies.pop_front();
            if (ok !== e.ok) begin
                errors++;
                $display("%0t: ok expected %0d actual %0d", $time, e.ok, ok);
            end
            if (count !== e.count) begin
                errors++;
                $display("%0t: count expected %0d actual %0d", $time, e.count, count);
            end
            if (data !== e.data) begin
                errors++;
                $display("%0t: data_out expected %h actual %h", $time, e.data, data);
            end
            if (level !== e.level) begin
                errors++;
                $display("%0t: fill_level expected %0d actual %0d", $time, e.level, level);
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic [2:0] s_operation;
    logic [3:0] s_length;
    logic [63:0] s_data_in;
    logic m_valid;
    logic m_ready;
    logic m_ok;
    logic [3:0] m_count;
    logic [63:0] m_data_out;
    logic [LVL_W-1:0] m_fill_level;

    ring_mirror board = new();
    int send_idle_pct;
    int results_seen;

    byte_ring_buffer #(
        .DEPTH(DEPTH),
        .LANES(LANES)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_operation(s_operation),
        .s_length(s_length),
        .s_data_in(s_data_in),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_ok(m_ok),
        .m_count(m_count),
        .m_data_out(m_data_out),
        .m_fill_level(m_fill_level)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int idle_span();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_word(input logic [2:0] op, input logic [3:0] len,
                             input logic [63:0] data);
        int gap;
        s_valid <= 1'b1;
        s_operation <= op;
        s_length <= len;
        s_data_in <= data;
        do @(posedge aclk); while (!s_ready);
        board.note_request(op, len, data);
        gap = ($urandom_range(0, 99) < send_idle_pct) ? idle_span() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_random(input traffic_mode_t mode);
        logic [2:0] op;
        logic [3:0] len;
        int pick;
        pick = $urandom_range(0, 99);
        case (mode)
            MODE_FILL: begin
                if (pick < 90) op = OP_PUSH;
                else if (pick < 95) op = OP_POP;
                else op = OP_TRY_PICK;
            end
            MODE_DRAIN: begin
                if (pick < 10) op = OP_PUSH;
                else if (pick < 40) op = OP_POP;
                else if (pick < 52) op = OP_PICK;
                else if (pick < 67) op = OP_SKIP;
                else if (pick < 87) op = OP_TRY_POP;
                else if (pick < 97) op = OP_TRY_PICK;
                else if (pick < 98) op = OP_CLEAR;
                else op = OP_UNUSED;
            end
            default: begin
                if (pick < 97) op = 3'($urandom_range(0, 6));
                else op = OP_UNUSED;
                if (op == OP_CLEAR && $urandom_range(0, 3) != 0) op = OP_PUSH;
            end
        endcase
        if ($urandom_range(0, 99) < 5) len = 4'($urandom_range(9, 15));
        else if (mode == MODE_FILL && op == OP_PUSH && $urandom_range(0, 99) < 80) len = 4'd8;
        else len = 4'($urandom_range(0, 8));
        send_word(op, len, {$urandom(), $urandom()});
    endtask

    initial begin
        int hold_left;
        int stall_pct;
        int cycle;
        bit long_hold_done;
        hold_left = 0;
        stall_pct = 0;
        cycle = 0;
        long_hold_done = 1'b0;
        results_seen = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                board.check_reply(m_ok, m_count, m_data_out, m_fill_level);
                results_seen++;
            end
            cycle++;
            if (cycle % 256 == 0) begin
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 10;
                    default: stall_pct = 40;
                endcase
            end
            if (hold_left == 0) begin
                if (!long_hold_done && results_seen >= 400) begin
                    long_hold_done = 1'b1;
                    hold_left = 300;
                end else if ($urandom_range(0, 99) < stall_pct) begin
                    hold_left = idle_span();
                end
            end
            if (!aresetn) begin
                m_ready <= 1'b0;
            end else if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        traffic_mode_t mode;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_operation <= OP_CLEAR;
        s_length <= 4'd0;
        s_data_in <= 64'd0;
        send_idle_pct = 20;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        send_word(OP_CLEAR, 4'd0, 64'd0);
        send_word(OP_PUSH, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(OP_POP, 4'd0, 64'd0);
        send_word(OP_PICK, 4'd0, 64'd0);
        send_word(OP_SKIP, 4'd0, 64'd0);
        send_word(OP_POP, 4'd1, 64'd0);
        send_word(OP_TRY_POP, 4'd8, 64'd0);
        send_word(OP_TRY_PICK, 4'd15, 64'd0);
        send_word(OP_PUSH, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(OP_PUSH, 4'd8, 64'd0);
        send_word(OP_PUSH, 4'd1, 64'h0000_0000_0000_00A5);
        send_word(OP_PUSH, 4'd9, 64'h0123_4567_89AB_CDEF);
        send_word(OP_PICK, 4'd8, 64'd0);
        send_word(OP_POP, 4'd8, 64'd0);
        send_word(OP_SKIP, 4'd3, 64'd0);
        send_word(OP_POP, 4'd9, 64'd0);
        send_word(OP_PICK, 4'd15, 64'd0);
        send_word(OP_TRY_PICK, 4'd15, 64'd0);
        send_word(OP_TRY_POP, 4'd15, 64'd0);
        send_word(OP_UNUSED, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(OP_PUSH, 4'd5, {$urandom(), $urandom()});
        send_word(OP_CLEAR, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(OP_PICK, 4'd1, 64'd0);

        for (int p = 0; p < PHASES; p++) begin
            case (p % 3)
                0: mode = MODE_FILL;
                1: mode = MODE_MIXED;
                default: mode = MODE_DRAIN;
            endcase
            case ($urandom_range(0, 2))
                0: send_idle_pct = 0;
                1: send_idle_pct = 15;
                default: send_idle_pct = 50;
            endcase
            for (int k = 0; k < PHASE_WORDS; k++) send_random(mode);
        end
        s_valid <= 1'b0;

        while (board.pending_replies.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (board.errors == 0) begin
            $display("byte_ring_buffer: match");
        end else begin
            $display("byte_ring_buffer: mismatch");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("byte_ring_buffer: mismatch");
        $finish;
    end

endmodule

>>> byte_ring_buffer.f
+incdir+rtl
rtl/brb_pkg.sv
rtl/brb_bank.sv
rtl/brb_merge.sv
rtl/byte_ring_buffer.sv
rtl/brb_checker.sv
dv/tb_byte_ring_buffer.sv
